// ===== rtl/mfir_pkg.sv =====
// shared types, widths and constants of the multichannel fir filter
`timescale 1ns / 1ps

package mfir_pkg;

  // default sizes
  localparam int TAPS_DEF     = 8;
  localparam int CHANNELS_DEF = 4;

  // coefficient register file
  localparam int NUM_COEFS  = 8;
  localparam int COEF_IDX_W = $clog2(NUM_COEFS);
  localparam int COEF_W     = 16;

  // sample and arithmetic widths
  localparam int SAMPLE_W  = 16;
  localparam int CHAN_W    = 2;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_COEFS);
  localparam int FRAC_BITS = 15;
  localparam int ROUND_W   = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0]   ROUND_BIAS = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [ROUND_W-1:0] SAT_MAX    = ROUND_W'(32767);
  localparam logic signed [ROUND_W-1:0] SAT_MIN    = ROUND_W'(-32768);

  localparam logic signed [COEF_W-1:0] COEF0_RESET = 16'sh7fff;

  // request kinds carried in the input tuser
  typedef enum logic {
    REQ_FILTER = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  // control that travels with one tap read through the mac pipeline
  typedef struct packed {
    logic                  vld;
    logic                  tap_on;
    logic                  first;
    logic                  last;
    logic [COEF_IDX_W-1:0] tap;
  } mac_ctl_t;

endpackage

// ===== rtl/multichannel_fir_filter.sv =====
// Multichannel direct-form FIR filter, one history per channel, shared coefficients.
// Input beats (s_axis): tuser[0] is the request kind (0 filter, 1 clear all
// histories), tuser[2:1] the channel, tdata[15:0] the signed sample.
// Output beats (m_axis): tuser[1:0] channel, tuser[2] saturation flag,
// tdata[15:0] rounded, saturated Q1.15 filter result.
// Coefficients coef_0..coef_7 are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the block is idle, which the
// block itself does not enforce. Only the first TAPS are used. A sample is
// written into a circular history in one memory; the taps are then read back
// one per cycle through the single read port and fed to one shared multiplier
// that sums them into the result in the output register, and the next beat is
// taken right after that result is loaded. Clear beats and beats for a channel
// at or above CHANNELS give no result and leave input ready.
// A per-channel fill count masks history slots never written since reset or
// the last clear, so neither needs a pass over the memory.
// Reset returns coef_0 to 32767, the other coefficients to 0 and empties all
// histories. A stalled receiver holds the result in the output register; one
// further beat is accepted and computed, then input waits.
`timescale 1ns / 1ps

module multichannel_fir_filter #(
  parameter int TAPS     = mfir_pkg::TAPS_DEF,
  parameter int CHANNELS = mfir_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: sample_in[15:0]
  input  logic [15:0]                         s_axis_tdata,
  // tuser: req_type[0], chan_sel[2:1]
  input  logic [2:0]                          s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: filtered[15:0]
  output logic [15:0]                         m_axis_tdata,
  // tuser: chan_out[1:0], saturated[2]
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [mfir_pkg::COEF_IDX_W-1:0]     cfg_idx_i,
  input  logic [mfir_pkg::COEF_W-1:0]         cfg_data_i
);

  localparam int SW    = $clog2(TAPS);
  localparam int CW    = $clog2(TAPS + 1);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * (2 ** SW);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e state_q;

  mfir_pkg::coef_t coef_q [mfir_pkg::NUM_COEFS];

  logic [SW-1:0]  head_q [CHANNELS];
  logic [CW-1:0]  cnt_q  [CHANNELS];
  logic [CHW-1:0] ch_q;
  logic [SW-1:0]  slot_q;
  logic [SW-1:0]  rd_k_q;
  logic [CW-1:0]  ncnt_q;

  logic                                m_tvalid_q;
  logic [mfir_pkg::SAMPLE_W-1:0]       m_data_q;
  logic [mfir_pkg::CHAN_W-1:0]         m_chan_q;
  logic                                m_sat_q;

  logic                                s_accept;
  mfir_pkg::req_e                      req;
  logic [mfir_pkg::CHAN_W-1:0]         in_chan;
  logic                                chan_ok;
  logic [CHW-1:0]                      in_ch;
  logic [SW-1:0]                       head_sel, new_slot, rd_slot;
  logic [CW-1:0]                       cnt_sel, new_cnt;
  logic                                wr_en, rd_en, out_free, out_load;
  logic [AW-1:0]                       waddr, raddr;
  logic [mfir_pkg::SAMPLE_W-1:0]       rdata;
  mfir_pkg::mac_ctl_t                  mac_ctl;
  logic                                mac_ready;
  logic signed [mfir_pkg::SAMPLE_W-1:0] mac_result;
  logic                                mac_sat;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mfir_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[0] <= mfir_pkg::COEF0_RESET;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // input beat decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign req           = mfir_pkg::req_e'(s_axis_tuser[0]);
  assign in_chan       = s_axis_tuser[2:1];
  assign chan_ok       = int'(in_chan) < CHANNELS;
  assign in_ch         = CHW'(in_chan);
  assign head_sel      = head_q[in_ch];
  assign cnt_sel       = cnt_q[in_ch];
  assign new_slot      = (head_sel == SW'(TAPS - 1)) ? '0 : head_sel + 1'b1;
  assign new_cnt       = (cnt_sel == CW'(TAPS)) ? cnt_sel : cnt_sel + 1'b1;

  // newest sample goes into the slot after the channel's head
  assign wr_en = s_accept && (req == mfir_pkg::REQ_FILTER) && chan_ok;
  assign waddr = AW'({in_ch, new_slot});

  // tap k lives k slots behind the newest, modulo TAPS
  assign rd_en   = (state_q == ST_RUN);
  assign rd_slot = (slot_q >= rd_k_q) ? slot_q - rd_k_q : slot_q + SW'(TAPS) - rd_k_q;
  assign raddr   = AW'({ch_q, rd_slot});

  always_comb begin
    mac_ctl        = '0;
    mac_ctl.vld    = rd_en;
    mac_ctl.tap_on = CW'(rd_k_q) < ncnt_q;
    mac_ctl.first  = (rd_k_q == '0);
    mac_ctl.last   = (rd_k_q == SW'(TAPS - 1));
    mac_ctl.tap    = mfir_pkg::COEF_IDX_W'(rd_k_q);
  end

  mfir_hist_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (mfir_pkg::SAMPLE_W)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mfir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .rdata_i  ($signed(rdata)),
    .coef_i   (coef_q),
    .ready_o  (mac_ready),
    .result_o (mac_result),
    .sat_o    (mac_sat)
  );

  // output register loads when the sum is done and the slot is free
  assign out_free = !m_tvalid_q || m_axis_tready;
  assign out_load = (state_q == ST_DRAIN) && mac_ready && out_free;

  // sequencer, channel pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_k_q     <= '0;
      m_tvalid_q <= 1'b0;
      m_data_q   <= '0;
      m_chan_q   <= '0;
      m_sat_q    <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_data_q   <= mac_result;
        m_chan_q   <= mfir_pkg::CHAN_W'(ch_q);
        m_sat_q    <= mac_sat;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if (req == mfir_pkg::REQ_CLEAR) begin
              for (int c = 0; c < CHANNELS; c++) begin
                cnt_q[c] <= '0;
              end
            end else if (chan_ok) begin
              head_q[in_ch] <= new_slot;
              cnt_q[in_ch]  <= new_cnt;
              rd_k_q        <= '0;
              state_q       <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rd_k_q <= rd_k_q + 1'b1;
          if (rd_k_q == SW'(TAPS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // item context
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ch_q   <= in_ch;
      slot_q <= new_slot;
      ncnt_q <= new_cnt;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = {m_sat_q, m_chan_q};

`ifndef SYNTHESIS
  // no tap read while a new beat can be taken
  a_ready_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rd_en)
    else $error("tap read while input ready");

  // an accepted sample starts its tap reads at tap zero
  a_start_tap0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (rd_en && rd_k_q == '0))
    else $error("tap sweep did not start at tap zero");

  // fill count of the running item counts its own sample and stays within TAPS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (ncnt_q != '0 && ncnt_q <= CW'(TAPS)))
    else $error("fill count out of range");
`endif

endmodule

// ===== rtl/mfir_hist_ram.sv =====
// sample history memory, one write port and one registered read port
`timescale 1ns / 1ps

module mfir_hist_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mfir_mac.sv =====
// shared multiply-accumulate with rounding and saturation of the sum
`timescale 1ns / 1ps

module mfir_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mfir_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [mfir_pkg::SAMPLE_W-1:0]  rdata_i,
  input  mfir_pkg::coef_t                       coef_i [mfir_pkg::NUM_COEFS],
  output logic                                  ready_o,
  output logic signed [mfir_pkg::SAMPLE_W-1:0]  result_o,
  output logic                                  sat_o
);

  mfir_pkg::mac_ctl_t ctl1_q, ctl2_q;
  logic signed [mfir_pkg::SAMPLE_W-1:0] operand;
  logic signed [mfir_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic signed [mfir_pkg::ACC_W-1:0]    prod_ext;
  logic signed [mfir_pkg::ACC_W-1:0]    acc_d, acc_q;
  logic signed [mfir_pkg::ACC_W-1:0]    biased, shifted;
  logic signed [mfir_pkg::ROUND_W-1:0]  y_wide;
  logic                                 ready_q;

  // taps past the fill count of the channel read as zero
  assign operand = ctl1_q.tap_on ? rdata_i : '0;
  assign prod_d  = mfir_pkg::PROD_W'(operand) * mfir_pkg::PROD_W'(coef_i[ctl1_q.tap]);

  // accumulate, first tap restarts the sum
  assign prod_ext = mfir_pkg::ACC_W'(prod_q);
  assign acc_d    = ctl2_q.first ? prod_ext : acc_q + prod_ext;

  // control pipeline and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      if (ctl1_q.vld) begin
        ready_q <= 1'b0;
      end else if (ctl2_q.vld && ctl2_q.last) begin
        ready_q <= 1'b1;
      end
    end
  end

  // product and accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl2_q.vld) begin
      acc_q <= acc_d;
    end
  end

  // round half up, then clip to 16 bits
  assign biased  = acc_q + mfir_pkg::ROUND_BIAS;
  assign shifted = biased >>> mfir_pkg::FRAC_BITS;
  assign y_wide  = shifted[mfir_pkg::ROUND_W-1:0];

  always_comb begin
    sat_o    = 1'b0;
    result_o = y_wide[mfir_pkg::SAMPLE_W-1:0];
    if (y_wide > mfir_pkg::SAT_MAX) begin
      sat_o    = 1'b1;
      result_o = mfir_pkg::SAT_MAX[mfir_pkg::SAMPLE_W-1:0];
    end else if (y_wide < mfir_pkg::SAT_MIN) begin
      sat_o    = 1'b1;
      result_o = mfir_pkg::SAT_MIN[mfir_pkg::SAMPLE_W-1:0];
    end
  end

  assign ready_o = ready_q;

endmodule
